[hw/rtl/ttrq_pkg.sv]
// -----------------------------------------------------------------------------
// ttrq_pkg
// Shared types, codes and defaults of the thread table and ready queue
// scheduler.
// -----------------------------------------------------------------------------
package ttrq_pkg;

   localparam int PROC_SLOTS_DEF       = 16;
   localparam int THREADS_PER_PROC_DEF = 4;

   localparam logic [1:0] ACT_CREATE   = 2'd0;
   localparam logic [1:0] ACT_ADD      = 2'd1;
   localparam logic [1:0] ACT_DESTROY  = 2'd2;
   localparam logic [1:0] ACT_SCHEDULE = 2'd3;

   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_NO_SLOT     = 3'd1;
   localparam logic [2:0] STAT_LIMIT       = 3'd2;
   localparam logic [2:0] STAT_NO_PROCESS  = 3'd3;
   localparam logic [2:0] STAT_QUEUE_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  pid;
      logic [63:0] start_address;
      logic [63:0] space_root;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  result_pid;
      logic [1:0]  thread_index;
      logic [63:0] chosen_root;
      logic [63:0] chosen_start;
      logic        space_changed;
   } rsp_type;

   // Datapath operations, one per cycle.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_SCAN_STEP,
      CMD_CREATE,
      CMD_ADD,
      CMD_ERR_SLOT,
      CMD_ERR_LIMIT,
      CMD_ERR_PROC,
      CMD_ERR_EMPTY,
      CMD_DEST_START,
      CMD_DEST_READ,
      CMD_DEST_MOVE,
      CMD_DEST_END,
      CMD_SCHED_HEAD,
      CMD_SCHED_FETCH,
      CMD_SCHED_OLD,
      CMD_SCHED_END,
      CMD_LOAD
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       found;
      logic       full;
      logic       scan_free;
      logic       scan_end;
      logic       dest_done;
      logic       queue_empty;
   } dp_status_type;

endpackage

[hw/rtl/thread_table_ready_queue_scheduler_core.sv]
// Create examines one slot per cycle; destroy reads each queued thread from the ring
// and writes it back only if it belongs to another process.
// Throughput: one request at a time; the next is taken once the result sits in
// the output register, which may still be waiting for rsp_ready.
// Reset: synchronous, active high; clears the slot table, queue pointers and the
// running thread. Root, entry and ring memories need no clearing.
// -----------------------------------------------------------------------------
// thread_table_ready_queue_scheduler_core
// Round-robin thread scheduler with a process slot table and a ready ring.
// -----------------------------------------------------------------------------
module thread_table_ready_queue_scheduler_core #(
   parameter int PROC_SLOTS       = ttrq_pkg::PROC_SLOTS_DEF,
   parameter int THREADS_PER_PROC = ttrq_pkg::THREADS_PER_PROC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttrq_pkg::rsp_type rsp_data
);
   import ttrq_pkg::*;

   // The controller issues one datapath command per cycle and watches the
   // status group that the datapath returns.
   cmd_type       cmd;
   dp_status_type dp_status;

   ttrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // The datapath holds all tables, the ring and the result output register,
   // so a finished transfer can wait while the next request is accepted.
   ttrq_dp #(
      .PROC_SLOTS       (PROC_SLOTS),
      .THREADS_PER_PROC (THREADS_PER_PROC)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/ttrq_ctrl.sv]
// -----------------------------------------------------------------------------
// ttrq_ctrl
// Sequencing state machine: decodes the action and steps the datapath.
// -----------------------------------------------------------------------------
module ttrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ttrq_pkg::dp_status_type dp_status,
   output ttrq_pkg::cmd_type      cmd
);
   import ttrq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECODE  = 9'b000000010,
      ST_SCAN    = 9'b000000100,
      ST_DEST_RD = 9'b000001000,
      ST_DEST_WR = 9'b000010000,
      ST_SCHED_A = 9'b000100000,
      ST_SCHED_B = 9'b001000000,
      ST_SCHED_C = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (dp_status.action)
               ACT_CREATE: state_in = ST_SCAN;
               ACT_ADD: begin
                  state_in = ST_DONE;
                  priority if (!dp_status.found) cmd = CMD_ERR_PROC;
                  else if (dp_status.full)       cmd = CMD_ERR_LIMIT;
                  else                           cmd = CMD_ADD;
               end
               ACT_DESTROY: begin
                  if (!dp_status.found) begin
                     cmd      = CMD_ERR_PROC;
                     state_in = ST_DONE;
                  end else begin
                     cmd      = CMD_DEST_START;
                     state_in = ST_DEST_RD;
                  end
               end
               ACT_SCHEDULE: begin
                  if (dp_status.queue_empty) begin
                     cmd      = CMD_ERR_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     cmd      = CMD_SCHED_HEAD;
                     state_in = ST_SCHED_A;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SCAN: begin
            priority if (dp_status.scan_end) begin
               cmd      = CMD_ERR_SLOT;
               state_in = ST_DONE;
            end else if (dp_status.scan_free) begin
               cmd      = CMD_CREATE;
               state_in = ST_DONE;
            end else begin
               cmd = CMD_SCAN_STEP;
            end
         end
         ST_DEST_RD: begin
            if (dp_status.dest_done) begin
               cmd      = CMD_DEST_END;
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_DEST_READ;
               state_in = ST_DEST_WR;
            end
         end
         ST_DEST_WR: begin
            cmd      = CMD_DEST_MOVE;
            state_in = ST_DEST_RD;
         end
         ST_SCHED_A: begin
            cmd      = CMD_SCHED_FETCH;
            state_in = ST_SCHED_B;
         end
         ST_SCHED_B: begin
            cmd      = CMD_SCHED_OLD;
            state_in = ST_SCHED_C;
         end
         ST_SCHED_C: begin
            cmd      = CMD_SCHED_END;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd      = CMD_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd == CMD_LOAD)  rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/ttrq_dp.sv]
// -----------------------------------------------------------------------------
// ttrq_dp
// Datapath: slot table, thread entry and root memories, ready ring, result.
// -----------------------------------------------------------------------------
module ttrq_dp #(
   parameter int PROC_SLOTS       = ttrq_pkg::PROC_SLOTS_DEF,
   parameter int THREADS_PER_PROC = ttrq_pkg::THREADS_PER_PROC_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ttrq_pkg::cmd_type       cmd,
   input  ttrq_pkg::req_type       req_data,
   output ttrq_pkg::dp_status_type dp_status,
   output ttrq_pkg::rsp_type       rsp_data
);
   import ttrq_pkg::*;

   localparam int TOTAL   = PROC_SLOTS * THREADS_PER_PROC;
   localparam int SLOT_W  = $clog2(PROC_SLOTS);
   localparam int IDX_W   = (THREADS_PER_PROC > 1) ? $clog2(THREADS_PER_PROC) : 1;
   localparam int ID_W    = SLOT_W + IDX_W;
   localparam int CNT_W   = $clog2(THREADS_PER_PROC + 1);
   localparam int RING_W  = $clog2(TOTAL);
   localparam int COUNT_W = $clog2(TOTAL + 1);
   localparam int SCAN_W  = $clog2(PROC_SLOTS + 1);

   function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] p);
      ring_next = (p == RING_W'(TOTAL - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [4:0] pid_of(input logic [SLOT_W-1:0] s);
      logic [6:0] sum;
      sum    = 7'(s) + 7'd1;
      pid_of = sum[4:0];
   endfunction

   // Memories.
   logic [63:0]     root_mem  [PROC_SLOTS];
   logic [63:0]     entry_mem [2**ID_W];
   logic [ID_W-1:0] ring_mem  [TOTAL];

   logic [63:0]     root_q_ff, entry_q_ff;
   logic [ID_W-1:0] ring_q_ff;

   logic              root_we, entry_we, ring_we;
   logic [SLOT_W-1:0] root_waddr, root_raddr;
   logic [ID_W-1:0]   entry_waddr, entry_raddr;
   logic [RING_W-1:0] ring_waddr, ring_raddr;
   logic [ID_W-1:0]   ring_wdata;

   // Table and queue state.
   logic [PROC_SLOTS-1:0] in_use_ff, in_use_in;
   logic [CNT_W-1:0]      threads_ff [PROC_SLOTS];
   logic [CNT_W-1:0]      threads_in [PROC_SLOTS];
   logic [RING_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [RING_W-1:0]     rd_ff, rd_in, wr_ff, wr_in;
   logic [COUNT_W-1:0]    count_ff, count_in, i_ff, i_in, kept_ff, kept_in;
   logic                  run_valid_ff, run_valid_in;
   logic [ID_W-1:0]       run_id_ff, run_id_in, next_ff, next_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   req_type               req_ff, req_in;
   rsp_type               res_ff, res_in, out_ff, out_in;

   logic [5:0]        pid_m1;
   logic [SLOT_W-1:0] slot, scan_slot;
   logic [CNT_W-1:0]  idx;

   assign pid_m1    = 6'(req_ff.pid) - 6'd1;
   assign slot      = pid_m1[SLOT_W-1:0];
   assign scan_slot = scan_ff[SLOT_W-1:0];
   assign idx       = threads_ff[slot];

   assign dp_status.action      = req_ff.action;
   assign dp_status.found       = (req_ff.pid != 5'd0) &&
                                  (7'(req_ff.pid) <= 7'(PROC_SLOTS)) && in_use_ff[slot];
   assign dp_status.full        = (idx >= CNT_W'(THREADS_PER_PROC));
   assign dp_status.scan_free   = !in_use_ff[scan_slot];
   assign dp_status.scan_end    = (scan_ff == SCAN_W'(PROC_SLOTS));
   assign dp_status.dest_done   = (i_ff == count_ff);
   assign dp_status.queue_empty = (count_ff == '0);
   assign rsp_data              = out_ff;

   always_comb begin
      in_use_in    = in_use_ff;
      threads_in   = threads_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      kept_in      = kept_ff;
      run_valid_in = run_valid_ff;
      run_id_in    = run_id_ff;
      next_in      = next_ff;
      scan_in      = scan_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      root_we      = 1'b0;
      entry_we     = 1'b0;
      ring_we      = 1'b0;
      root_waddr   = scan_slot;
      entry_waddr  = {slot, idx[IDX_W-1:0]};
      ring_waddr   = tail_ff;
      ring_wdata   = {slot, idx[IDX_W-1:0]};
      root_raddr   = ring_q_ff[ID_W-1:IDX_W];
      entry_raddr  = ring_q_ff;
      ring_raddr   = head_ff;

      unique case (cmd)
         CMD_NONE: ;
         CMD_CAPTURE: begin
            req_in  = req_data;
            res_in  = '0;
            scan_in = '0;
         end
         CMD_SCAN_STEP: scan_in = scan_ff + 1'b1;
         CMD_CREATE: begin
            in_use_in[scan_slot]  = 1'b1;
            threads_in[scan_slot] = CNT_W'(1);
            root_we               = 1'b1;
            entry_we              = 1'b1;
            entry_waddr           = {scan_slot, IDX_W'(0)};
            ring_wdata            = {scan_slot, IDX_W'(0)};
            if (count_ff < COUNT_W'(TOTAL)) begin
               ring_we  = 1'b1;
               tail_in  = ring_next(tail_ff);
               count_in = count_ff + 1'b1;
            end
            res_in.result_pid = pid_of(scan_slot);
         end
         CMD_ADD: begin
            threads_in[slot] = idx + 1'b1;
            entry_we         = 1'b1;
            if (count_ff < COUNT_W'(TOTAL)) begin
               ring_we  = 1'b1;
               tail_in  = ring_next(tail_ff);
               count_in = count_ff + 1'b1;
            end
            res_in.result_pid   = req_ff.pid;
            res_in.thread_index = 2'(idx);
         end
         CMD_ERR_SLOT:  res_in.status = STAT_NO_SLOT;
         CMD_ERR_LIMIT: begin
            res_in.status     = STAT_LIMIT;
            res_in.result_pid = req_ff.pid;
         end
         CMD_ERR_PROC:  res_in.status = STAT_NO_PROCESS;
         CMD_ERR_EMPTY: res_in.status = STAT_QUEUE_EMPTY;
         CMD_DEST_START: begin
            rd_in   = head_ff;
            wr_in   = head_ff;
            i_in    = '0;
            kept_in = '0;
         end
         CMD_DEST_READ: ring_raddr = rd_ff;
         CMD_DEST_MOVE: begin
            if (ring_q_ff[ID_W-1:IDX_W] != slot) begin
               ring_we    = 1'b1;
               ring_waddr = wr_ff;
               ring_wdata = ring_q_ff;
               wr_in      = ring_next(wr_ff);
               kept_in    = kept_ff + 1'b1;
            end
            rd_in = ring_next(rd_ff);
            i_in  = i_ff + 1'b1;
         end
         CMD_DEST_END: begin
            tail_in  = wr_ff;
            count_in = kept_ff;
            if (run_valid_ff && (run_id_ff[ID_W-1:IDX_W] == slot)) run_valid_in = 1'b0;
            in_use_in[slot]   = 1'b0;
            threads_in[slot]  = '0;
            res_in.result_pid = req_ff.pid;
         end
         CMD_SCHED_HEAD: ring_raddr = head_ff;
         CMD_SCHED_FETCH: begin
            next_in  = ring_q_ff;
            head_in  = ring_next(head_ff);
            count_in = count_ff - 1'b1;
         end
         CMD_SCHED_OLD: begin
            res_in.chosen_root  = root_q_ff;
            res_in.chosen_start = entry_q_ff;
            root_raddr          = run_id_ff[ID_W-1:IDX_W];
         end
         CMD_SCHED_END: begin
            if (run_valid_ff) begin
               res_in.space_changed = (root_q_ff != res_ff.chosen_root);
               if (run_id_ff != next_ff) begin
                  if (count_ff < COUNT_W'(TOTAL)) begin
                     ring_we    = 1'b1;
                     ring_wdata = run_id_ff;
                     tail_in    = ring_next(tail_ff);
                     count_in   = count_ff + 1'b1;
                  end
               end
            end else begin
               res_in.space_changed = 1'b1;
            end
            run_valid_in        = 1'b1;
            run_id_in           = next_ff;
            res_in.result_pid   = pid_of(next_ff[ID_W-1:IDX_W]);
            res_in.thread_index = 2'(next_ff[IDX_W-1:0]);
         end
         CMD_LOAD: out_in = res_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (root_we)  root_mem[root_waddr]   <= req_ff.space_root;
      if (entry_we) entry_mem[entry_waddr] <= req_ff.start_address;
      if (ring_we)  ring_mem[ring_waddr]   <= ring_wdata;
      root_q_ff  <= root_mem[root_raddr];
      entry_q_ff <= entry_mem[entry_raddr];
      ring_q_ff  <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         threads_ff   <= '{default: '0};
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
      end else begin
         in_use_ff    <= in_use_in;
         threads_ff   <= threads_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_id_ff    <= run_id_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      i_ff    <= i_in;
      kept_ff <= kept_in;
      next_ff <= next_in;
      scan_ff <= scan_in;
      req_ff  <= req_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

endmodule

[hw/rtl/ttrq_checker.sv]
// -----------------------------------------------------------------------------
// ttrq_checker
// Port-level checks of the scheduler, bound to the top level.
// -----------------------------------------------------------------------------
module ttrq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ttrq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ttrq_pkg::rsp_type rsp_data
);
   import ttrq_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_QUEUE_EMPTY || rsp_data.status == STAT_NO_PROCESS)
      |-> rsp_data.result_pid == 5'd0 && !rsp_data.space_changed)
      else $error("error result carries data");

endmodule

bind thread_table_ready_queue_scheduler_core ttrq_checker u_ttrq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin thread scheduler. A behavioral
// copy of the slot table and ready ring predicts every response; responses
// are compared field by field as they come back.
// -----------------------------------------------------------------------------
module tb_top;
   import ttrq_pkg::*;

   localparam int SLOTS   = PROC_SLOTS_DEF;
   localparam int THREADS = THREADS_PER_PROC_DEF;
   localparam int TOTAL   = SLOTS * THREADS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   thread_table_ready_queue_scheduler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the scheduler state.
   bit          sh_used [SLOTS];
   int unsigned sh_count [SLOTS];
   logic [63:0] sh_root [SLOTS];
   logic [63:0] sh_entry [TOTAL];
   int unsigned ready_q[$];
   bit          run_valid;
   int unsigned run_id;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      sched_hits = 0;

   // The receiver stalls on its own pattern unless the long hold-off is on.
   bit hold_rsp = 1'b0;
   int stall_mode = 0;

   // Burst shaping for the sender.
   int burst_left = 0;

   function automatic int unsigned live_procs();
      int unsigned n;
      n = 0;
      for (int s = 0; s < SLOTS; s++) if (sh_used[s]) n++;
      return n;
   endfunction

   // Advances the shadow state by one request and returns the expected response.
   function automatic rsp_type predict_step(req_type r);
      rsp_type     o;
      int unsigned slot, idx, nxt, ns;
      bit          found;
      int unsigned keep[$];
      o = '0;
      found = (r.pid != 0 && r.pid <= SLOTS);
      slot = found ? r.pid - 1 : 0;
      if (found) found = sh_used[slot];
      case (r.action)
         ACT_CREATE: begin
            ns = SLOTS;
            for (int s = SLOTS - 1; s >= 0; s--) if (!sh_used[s]) ns = s;
            if (ns == SLOTS) begin
               o.status = STAT_NO_SLOT;
            end else begin
               sh_used[ns] = 1'b1;
               sh_root[ns] = r.space_root;
               sh_entry[ns * THREADS] = r.start_address;
               sh_count[ns] = 1;
               ready_q.push_back(ns * THREADS);
               o.result_pid = 5'(ns + 1);
            end
         end
         ACT_ADD: begin
            if (!found) begin
               o.status = STAT_NO_PROCESS;
            end else if (sh_count[slot] >= THREADS) begin
               o.status = STAT_LIMIT;
               o.result_pid = r.pid;
            end else begin
               idx = sh_count[slot];
               sh_entry[slot * THREADS + idx] = r.start_address;
               sh_count[slot] = idx + 1;
               ready_q.push_back(slot * THREADS + idx);
               o.thread_index = 2'(idx);
               o.result_pid = r.pid;
            end
         end
         ACT_DESTROY: begin
            if (!found) begin
               o.status = STAT_NO_PROCESS;
            end else begin
               foreach (ready_q[i]) if (ready_q[i] / THREADS != slot) keep.push_back(ready_q[i]);
               ready_q = keep;
               if (run_valid && run_id / THREADS == slot) run_valid = 1'b0;
               sh_used[slot] = 1'b0;
               sh_count[slot] = 0;
               o.result_pid = r.pid;
            end
         end
         default: begin
            if (ready_q.size() == 0) begin
               o.status = STAT_QUEUE_EMPTY;
            end else begin
               nxt = ready_q.pop_front();
               ns = nxt / THREADS;
               o.chosen_root = sh_root[ns];
               if (run_valid) begin
                  o.space_changed = (sh_root[run_id / THREADS] != o.chosen_root);
                  if (run_id != nxt) ready_q.push_back(run_id);
               end else begin
                  o.space_changed = 1'b1;
               end
               run_valid = 1'b1;
               run_id = nxt;
               o.result_pid = 5'(ns + 1);
               o.thread_index = 2'(nxt % THREADS);
               o.chosen_start = sh_entry[nxt];
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch at response %0d: %s got %h expected %h", checked_count, what, got,
               want);
   endtask

   // Sends one request, with bursts and random gaps between bursts. Valid stays
   // high inside a burst and only drops for a gap.
   task automatic send_request(req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_step(r));
      sent_count++;
      if (r.action == ACT_SCHEDULE) sched_hits++;
   endtask

   function automatic req_type make_req(logic [1:0] act, logic [4:0] pid);
      req_type r;
      r.action = act;
      r.pid = pid;
      r.start_address = {$urandom, $urandom};
      r.space_root = {$urandom, $urandom};
      return r;
   endfunction

   // Picks a pid that is mostly live, sometimes freed or out of range.
   function automatic logic [4:0] pick_pid();
      int unsigned live[$];
      for (int s = 0; s < SLOTS; s++) if (sh_used[s]) live.push_back(s + 1);
      if (live.size() != 0 && $urandom_range(0, 9) < 8)
         return 5'(live[$urandom_range(0, live.size() - 1)]);
      return 5'($urandom_range(0, 31));
   endfunction

   // Receiver: checks each transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_data.status), 64'd0);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.result_pid !== want.result_pid)
               report_mismatch("result_pid", 64'(rsp_data.result_pid),
                               64'(want.result_pid));
            if (rsp_data.thread_index !== want.thread_index)
               report_mismatch("thread_index", 64'(rsp_data.thread_index),
                               64'(want.thread_index));
            if (rsp_data.chosen_root !== want.chosen_root)
               report_mismatch("chosen_root", rsp_data.chosen_root, want.chosen_root);
            if (rsp_data.chosen_start !== want.chosen_start)
               report_mismatch("chosen_start", rsp_data.chosen_start, want.chosen_start);
            if (rsp_data.space_changed !== want.space_changed)
               report_mismatch("space_changed", 64'(rsp_data.space_changed),
                               64'(want.space_changed));
         end
         checked_count++;
      end
   end

   // Ready pattern: phases of always-ready, random stalls and slow random acceptance.
   always @(posedge clock) begin
      if (hold_rsp)
         rsp_ready <= 1'b0;
      else if (stall_mode == 0)
         rsp_ready <= 1'b1;
      else if (stall_mode == 1)
         rsp_ready <= ($urandom_range(0, 3) != 0);
      else
         rsp_ready <= ($urandom_range(0, 6) == 0);
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
   end

   // Directed: edge pids, every action, empty queue, slot table full, limits.
   task automatic test_directed();
      req_type r;
      send_request(make_req(ACT_SCHEDULE, 5'd0));
      send_request(make_req(ACT_ADD, 5'd0));
      send_request(make_req(ACT_DESTROY, 5'd31));
      r = make_req(ACT_CREATE, 5'd31);
      r.start_address = '1;
      r.space_root = '1;
      send_request(r);
      r = make_req(ACT_CREATE, 5'd0);
      r.start_address = '0;
      r.space_root = '0;
      send_request(r);
      for (int i = 0; i < 4; i++) send_request(make_req(ACT_ADD, 5'd1));
      send_request(make_req(ACT_SCHEDULE, 5'd0));
      send_request(make_req(ACT_SCHEDULE, 5'd0));
      send_request(make_req(ACT_SCHEDULE, 5'd0));
      for (int i = 0; i < 15; i++) send_request(make_req(ACT_CREATE, 5'd0));
      send_request(make_req(ACT_ADD, 5'd16));
      send_request(make_req(ACT_ADD, 5'd17));
      send_request(make_req(ACT_DESTROY, 5'd1));
      send_request(make_req(ACT_SCHEDULE, 5'd0));
   endtask

   // Well-formed random mix; creates are favoured while fewer than three processes live.
   task automatic test_random(int n);
      int      w;
      req_type r;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(0, 99);
         if (live_procs() < 3 && w < 50) w = 0;
         if (w < 20)      r = make_req(ACT_CREATE, 5'($urandom_range(0, 31)));
         else if (w < 45) r = make_req(ACT_ADD, pick_pid());
         else if (w < 58) r = make_req(ACT_DESTROY, pick_pid());
         else             r = make_req(ACT_SCHEDULE, 5'($urandom_range(0, 31)));
         send_request(r);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering requests.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            burst_left = 40;
            test_random(30);
         end
      join
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      test_backpressure();
      test_random(450);
      drain();
      $display("Ran %0d requests (%0d schedules) with %0d responses checked,", sent_count,
               sched_hits, checked_count);
      $display("including a full slot table, thread limits and a long output stall.");
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("timeout after %0d requests", sent_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule
